// File: src/resizing_stack_capacity_tracker_core_assert.svh
// Assertion macros shared by the stack tracker RTL.
`ifndef RESIZING_STACK_CAPACITY_TRACKER_CORE_ASSERT_SVH
`define RESIZING_STACK_CAPACITY_TRACKER_CORE_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define RSCT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define RSCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rsct_pkg.sv
`default_nettype none

package rsct_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int DATA_WIDTH = 32;
    localparam int CNT_FIELD_W = 11;
    localparam int RESIZE_W = 32;

    // Default number of stored words.
    localparam int DEPTH_DEFAULT = 1024;

    // Capacity after reset, also the reset shrink floor.
    localparam logic [CNT_FIELD_W-1:0] BASE_CAP_RESET = 11'd10;

    // Word returned by a pop on an empty stack.
    localparam logic signed [DATA_WIDTH-1:0] EMPTY_WORD = -32'sd99;

    typedef logic [CNT_FIELD_W-1:0] t_cnt_field;
    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_func func;
        t_word value;
    } t_in_item;

    typedef struct packed {
        t_word                popped_value;
        t_status              status;
        t_cnt_field           item_count;
        t_cnt_field           capacity_now;
        logic [RESIZE_W-1:0]  resize_total;
        t_cnt_field           peak_capacity;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/rsct_mem.sv
`default_nettype none

module rsct_mem #(
    parameter int DEPTH = rsct_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire rsct_pkg::t_word               i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output rsct_pkg::t_word                    o_rdata
);
    import rsct_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/resizing_stack_capacity_tracker_core.sv
// Resizing stack capacity tracker.
// Input channel (i_in_valid / o_in_ready, i_in_item) carries one push or pop.
// Output channel (o_out_valid / i_out_ready, o_out_item) returns exactly one
// result per operation: the popped word, a status, and the item count,
// logical capacity, resize total and peak capacity after the operation.
// The result of an accepted operation is registered and valid in the cycle
// after it is accepted. Throughput is one operation per cycle while the receiver
// takes each result; the single pass through the resize logic and one access
// to the word memory (one write port, one registered read port) set that figure.
// The result sits in an output register. A new operation is accepted while
// the held result is taken in the same cycle; while the receiver stalls, the
// result holds and o_in_ready is low.
// Synchronous reset clears the count and resize total, sets base, capacity
// and peak to 10 and empties the output. Stored words are not cleared.
// A write on i_cfg_we loads the clamped base into base, capacity and peak; the
// user must issue it only while no result is pending; the block does not enforce this.
`default_nettype none

module resizing_stack_capacity_tracker_core #(
    parameter int DEPTH = rsct_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire rsct_pkg::t_in_item                    i_in_item,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output rsct_pkg::t_out_item                        o_out_item,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rsct_pkg::CNT_FIELD_W-1:0]      i_cfg_wdata
);
    import rsct_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int GW = CNT_W + 3;

    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_cap, n_cap;
    logic [CNT_W-1:0]    r_peak, n_peak;
    logic [CNT_W-1:0]    r_base;
    logic [RESIZE_W-1:0] r_resize, n_resize;
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic                r_pop_ok, n_pop_ok;

    logic                in_acc;
    logic                chk;
    logic [CNT_W-1:0]    chk_n;
    logic [GW-1:0]       cap_ext;
    logic [GW-1:0]       grow_raw;
    logic [CNT_W-1:0]    grow_cap;
    logic [CNT_W-1:0]    cfg_base;
    logic                mem_we;
    logic                mem_re;
    t_word               mem_rdata;

    // Handshake: the output register frees up when its result is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc = i_in_valid && o_in_ready;

    // Grown capacity floor(cap * 7 / 4), saturated at the memory depth.
    assign cap_ext = GW'(r_cap);
    assign grow_raw = ((cap_ext << 3) - cap_ext) >> 2;
    assign grow_cap = (grow_raw > GW'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(grow_raw);

    // Base register write is clamped to 1..DEPTH.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_base = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(DEPTH)) begin
            cfg_base = CNT_W'(DEPTH);
        end else begin
            cfg_base = CNT_W'(i_cfg_wdata);
        end
    end

    // Operation decode, count update and resize decision.
    always_comb begin
        n_count  = r_count;
        n_cap    = r_cap;
        n_peak   = r_peak;
        n_resize = r_resize;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        chk      = 1'b0;
        chk_n    = r_count;
        mem_we   = 1'b0;
        mem_re   = 1'b0;

        unique case (i_in_item.func)
            FUNC_PUSH: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = in_acc;
                    n_count = r_count + 1'b1;
                    chk     = 1'b1;
                    chk_n   = n_count;
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    mem_re   = in_acc;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                    chk      = 1'b1;
                    chk_n    = r_count;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        if (chk) begin
            if (chk_n >= r_cap) begin
                n_cap = grow_cap;
                if (grow_cap > r_peak) begin
                    n_peak = grow_cap;
                end
                if (r_resize != '1) begin
                    n_resize = r_resize + 1'b1;
                end
            end else if ((chk_n <= (r_cap >> 1)) && (r_cap > r_base)) begin
                n_cap = r_cap >> 1;
                if (r_resize != '1) begin
                    n_resize = r_resize + 1'b1;
                end
            end
        end
    end

    // Stack words: push writes at the count, pop reads the top word.
    rsct_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_in_item.value),
        .i_re   (mem_re),
        .i_raddr(AW'(r_count - 1'b1)),
        .o_rdata(mem_rdata)
    );

    // State registers and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CNT_W'(BASE_CAP_RESET);
            r_peak      <= CNT_W'(BASE_CAP_RESET);
            r_base      <= CNT_W'(BASE_CAP_RESET);
            r_resize    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= cfg_base;
                r_cap  <= cfg_base;
                r_peak <= cfg_base;
            end else if (in_acc) begin
                r_count  <= n_count;
                r_cap    <= n_cap;
                r_peak   <= n_peak;
                r_resize <= n_resize;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // Result status, held until the next transfer is accepted.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Result fields come straight from the state after the operation.
    assign o_out_valid = r_out_valid;

    always_comb begin
        if (r_pop_ok) begin
            o_out_item.popped_value = mem_rdata;
        end else if (r_status == ST_EMPTY) begin
            o_out_item.popped_value = EMPTY_WORD;
        end else begin
            o_out_item.popped_value = '0;
        end
        o_out_item.status        = r_status;
        o_out_item.item_count    = t_cnt_field'(r_count);
        o_out_item.capacity_now  = t_cnt_field'(r_cap);
        o_out_item.resize_total  = r_resize;
        o_out_item.peak_capacity = t_cnt_field'(r_peak);
    end

`include "resizing_stack_capacity_tracker_core_assert.svh"

    `RSCT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    `RSCT_ASSERT_SAME(a_cap_le_peak, i_clk, i_rst_n, 1'b1, r_cap <= r_peak, "capacity above peak")
    `RSCT_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, in_acc && (i_in_item.func == FUNC_POP) && (r_count != '0), r_count == CNT_W'($past(r_count) - 1'b1), "pop did not lower count")
    `RSCT_ASSERT_NEXT(a_resize_mono, i_clk, i_rst_n, i_rst_n, r_resize >= $past(r_resize), "resize total went down")

endmodule

`default_nettype wire
